/* src/grc_pkg.sv */
// Shared types and constants for the grid ray wall column caster.
package grc_pkg;

  localparam int MAP_SIZE  = 32;
  localparam int MAP_AW    = $clog2(MAP_SIZE);
  localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int CELL_W    = 4;
  localparam int SCREEN_W  = 320;
  localparam int SCREEN_H  = 180;
  localparam int HALF_H    = SCREEN_H / 2;
  localparam int TEX_SIZE  = 64;
  localparam int TEX_BITS  = $clog2(TEX_SIZE);
  localparam int MAX_STEPS = 64;
  localparam int STEP_CW   = $clog2(MAX_STEPS + 1);

  localparam int DIV_W   = 29;  // dividend / quotient width
  localparam int DIV_DW  = 32;  // divisor width
  localparam int CAM_W   = 19;
  localparam int RAY_W   = 20;
  localparam int DELTA_W = 41;
  localparam int SD_W    = 48;
  localparam int PERP_W  = 32;
  localparam int COORD_W = MAP_AW + 2;
  localparam int CFG_AW  = 3;

  localparam logic [15:0] LH_MAX = 16'hFFFF;
  localparam logic [21:0] TS_MAX = 22'h3FFFFF;

  localparam logic [CFG_AW-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_PLANE_Y = 3'd5;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_MAPWR,
    OP_LOAD,
    OP_CAM_SAVE,
    OP_RAYX,
    OP_RAYY,
    OP_DX_START,
    OP_DX_SAVE,
    OP_DY_START,
    OP_DY_SAVE,
    OP_SIDEX,
    OP_SIDEY,
    OP_STEP,
    OP_CHECK,
    OP_PERP,
    OP_LH_START,
    OP_LH_SAVE,
    OP_TS_START,
    OP_TS_SAVE,
    OP_TEX,
    OP_TPOS,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic walk_hit;
    logic walk_end;
  } dp_status_t;

endpackage

/* src/grid_ray_wall_column_caster_top.sv */
// Top level of the grid ray wall column caster.
// Each input beat either writes one 4-bit wall code into the 32x32 map or
// casts one screen column through the map and returns one result beat. The
// DDA walk visits at most 64 cells. The serial divider, which yields one
// quotient bit per cycle, runs four 29-bit divisions per hit (both delta
// distances, line height, texture step), the camera offset is a reciprocal
// multiply, and each walk step passes through a stepping state and then a
// check state that reads the map RAM. One item is worked on at a time; the
// next beat is taken as soon as the result sits in the output register,
// even if that result is still stalled, and a following cast then waits for
// that register to drain before it finishes. Map cells never written read
// back as undefined. Configuration writes are always ready.
module grid_ray_wall_column_caster_top import grc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [4:0]        in_cell_x,
  input  logic [4:0]        in_cell_y,
  input  logic [3:0]        in_cell_value,
  input  logic [8:0]        in_column,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [8:0]        out_column_out,
  output logic              out_hit_found,
  output logic              out_hit_side,
  output logic [3:0]        out_texture_index,
  output logic [5:0]        out_texture_column,
  output logic [15:0]       out_wall_distance,
  output logic [15:0]       out_line_height,
  output logic [7:0]        out_draw_start,
  output logic [7:0]        out_draw_end,
  output logic [21:0]       out_texture_step,
  output logic [21:0]       out_texture_start
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  grc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_cell_value      (in_cell_value),
    .in_column          (in_column),
    .out_column_out     (out_column_out),
    .out_hit_found      (out_hit_found),
    .out_hit_side       (out_hit_side),
    .out_texture_index  (out_texture_index),
    .out_texture_column (out_texture_column),
    .out_wall_distance  (out_wall_distance),
    .out_line_height    (out_line_height),
    .out_draw_start     (out_draw_start),
    .out_draw_end       (out_draw_end),
    .out_texture_step   (out_texture_step),
    .out_texture_start  (out_texture_start)
  );

endmodule

/* src/grc_ram.sv */
// Generic single write port, single read port RAM with registered read.
module grc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/grc_div.sv */
// Serial restoring divider, one quotient bit per cycle.
module grc_div import grc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              busy,
  output logic [DIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_W-1:0]  dq_r;
  logic [DIV_DW-1:0] dvs_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = !diff[DIV_DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      dq_r  <= {dq_r[DIV_W-2:0], ge};
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = dq_r;

endmodule

/* src/grc_ctrl.sv */
// Sequencer for map writes and column casts.
module grc_ctrl import grc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CAM_WAIT, S_RAYX, S_RAYY,
    S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT,
    S_SIDEX, S_SIDEY, S_STEP, S_CHECK,
    S_PERP, S_LH_GO, S_LH_WAIT, S_TS_GO, S_TS_WAIT,
    S_TEX, S_TPOS, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind) begin
            cmd.op    = OP_LOAD;
            state_nxt = S_CAM_WAIT;
          end else begin
            cmd.op = OP_MAPWR;
          end
        end
      end
      S_CAM_WAIT: begin
        if (!status.div_busy) begin
          cmd.op    = OP_CAM_SAVE;
          state_nxt = S_RAYX;
        end
      end
      S_RAYX: begin
        cmd.op    = OP_RAYX;
        state_nxt = S_RAYY;
      end
      S_RAYY: begin
        cmd.op    = OP_RAYY;
        state_nxt = S_DX_GO;
      end
      S_DX_GO: begin
        cmd.op    = OP_DX_START;
        state_nxt = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (!status.div_busy) begin
          cmd.op    = OP_DX_SAVE;
          state_nxt = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.op    = OP_DY_START;
        state_nxt = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (!status.div_busy) begin
          cmd.op    = OP_DY_SAVE;
          state_nxt = S_SIDEX;
        end
      end
      S_SIDEX: begin
        cmd.op    = OP_SIDEX;
        state_nxt = S_SIDEY;
      end
      S_SIDEY: begin
        cmd.op    = OP_SIDEY;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.op    = OP_STEP;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op = OP_CHECK;
        if (status.walk_hit) begin
          state_nxt = S_PERP;
        end else if (status.walk_end) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_PERP: begin
        cmd.op    = OP_PERP;
        state_nxt = S_LH_GO;
      end
      S_LH_GO: begin
        cmd.op    = OP_LH_START;
        state_nxt = S_LH_WAIT;
      end
      S_LH_WAIT: begin
        if (!status.div_busy) begin
          cmd.op    = OP_LH_SAVE;
          state_nxt = S_TS_GO;
        end
      end
      S_TS_GO: begin
        cmd.op    = OP_TS_START;
        state_nxt = S_TS_WAIT;
      end
      S_TS_WAIT: begin
        if (!status.div_busy) begin
          cmd.op    = OP_TS_SAVE;
          state_nxt = S_TEX;
        end
      end
      S_TEX: begin
        cmd.op    = OP_TEX;
        state_nxt = S_TPOS;
      end
      S_TPOS: begin
        cmd.op    = OP_TPOS;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // output register free or draining this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/grc_dp.sv */
// Datapath: camera registers, map RAM, DDA walk, divider and result registers.
module grc_dp import grc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic              cfg_valid,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [4:0]        in_cell_x,
  input  logic [4:0]        in_cell_y,
  input  logic [3:0]        in_cell_value,
  input  logic [8:0]        in_column,
  output logic [8:0]        out_column_out,
  output logic              out_hit_found,
  output logic              out_hit_side,
  output logic [3:0]        out_texture_index,
  output logic [5:0]        out_texture_column,
  output logic [15:0]       out_wall_distance,
  output logic [15:0]       out_line_height,
  output logic [7:0]        out_draw_start,
  output logic [7:0]        out_draw_end,
  output logic [21:0]       out_texture_step,
  output logic [21:0]       out_texture_start
);

  localparam logic [DIV_W-1:0]   DVD_DELTA = DIV_W'(1) << 28;
  localparam logic [DIV_W-1:0]   DVD_LH    = DIV_W'(SCREEN_H * 65536);
  localparam logic [DIV_W-1:0]   DVD_TS    = DIV_W'(TEX_SIZE * 65536);
  localparam logic [DELTA_W-1:0] DELTA_INF = DELTA_W'(1) << 40;
  localparam logic [14:0]        HALF_H15  = 15'(HALF_H);
  // camera offset col * 2^17 / SCREEN_W by reciprocal multiply, exact for col < 2048
  localparam int                 CAM_SH    = 13;
  localparam logic [21:0]        CAM_RCP   =
    22'(((64'd1 << (17 + CAM_SH)) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  // camera registers
  logic [15:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  // per-cast working registers
  logic [8:0]               col_r;
  logic signed [CAM_W-1:0]  cam_r;
  logic signed [RAY_W-1:0]  rx_r, ry_r;
  logic [DELTA_W-1:0]       dx_r, dy_r;
  logic [SD_W-1:0]          sdx_r, sdy_r;
  logic [COORD_W-1:0]       mx_r, my_r;
  logic [STEP_CW-1:0]       n_r;
  logic                     side_r, oob_r, hit_r;
  logic [CELL_W-1:0]        cell_r;
  logic [PERP_W-1:0]        perp_r;
  logic [15:0]              lh_r;
  logic [21:0]              ts_r, tp_r;
  logic [TEX_BITS-1:0]      tx_r;

  // result registers
  logic [8:0]  o_col_r;
  logic        o_hit_r, o_side_r;
  logic [3:0]  o_tidx_r;
  logic [5:0]  o_tcol_r;
  logic [15:0] o_wd_r, o_lh_r;
  logic [7:0]  o_ds_r, o_de_r;
  logic [21:0] o_ts_r, o_tp_r;

  // divider
  logic              div_start, div_busy;
  logic [DIV_W-1:0]  div_dvd, div_q;
  logic [DIV_DW-1:0] div_dvs;

  // map
  logic                     ram_we;
  logic [2*MAP_AW-1:0]      ram_raddr;
  logic [CELL_W-1:0]        ram_rdata;

  logic [RAY_W-1:0] magx, magy;
  logic [30:0]      cam_prod;

  assign magx = rx_r[RAY_W-1] ? RAY_W'(-rx_r) : RAY_W'(rx_r);
  assign magy = ry_r[RAY_W-1] ? RAY_W'(-ry_r) : RAY_W'(ry_r);
  assign cam_prod = col_r * CAM_RCP;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVD_DELTA;
    div_dvs   = DIV_DW'(magx);
    case (cmd.op)
      OP_DX_START: begin
        div_start = 1'b1;
      end
      OP_DY_START: begin
        div_start = 1'b1;
        div_dvs   = DIV_DW'(magy);
      end
      OP_LH_START: begin
        div_start = 1'b1;
        div_dvd   = DVD_LH;
        div_dvs   = perp_r;
      end
      OP_TS_START: begin
        div_start = 1'b1;
        div_dvd   = DVD_TS;
        div_dvs   = DIV_DW'(lh_r);
      end
      default: begin
      end
    endcase
  end

  grc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // ray = dir + floor(plane * cam / 2^16)
  logic signed [15:0]      ray_plane, ray_dir;
  logic signed [34:0]      ray_prod;
  logic signed [RAY_W-1:0] ray_sum;

  assign ray_plane = (cmd.op == OP_RAYY) ? plane_y_r : plane_x_r;
  assign ray_dir   = (cmd.op == OP_RAYY) ? dir_y_r : dir_x_r;
  assign ray_prod  = ray_plane * cam_r;
  assign ray_sum   = RAY_W'(ray_dir) + RAY_W'(signed'(ray_prod[34:16]));

  // initial side distance
  logic [10:0]        sd_frac;
  logic               sd_neg;
  logic [11:0]        sd_fac;
  logic [DELTA_W-1:0] sd_del;
  logic [52:0]        sd_prod;

  assign sd_frac = (cmd.op == OP_SIDEY) ? pos_y_r[10:0] : pos_x_r[10:0];
  assign sd_neg  = (cmd.op == OP_SIDEY) ? ry_r[RAY_W-1] : rx_r[RAY_W-1];
  assign sd_del  = (cmd.op == OP_SIDEY) ? dy_r : dx_r;
  assign sd_fac  = sd_neg ? {1'b0, sd_frac} : 12'd2048 - {1'b0, sd_frac};
  assign sd_prod = sd_fac * sd_del;

  // one DDA step; ties go to y
  logic               x_go, oob;
  logic [COORD_W-1:0] nx, ny, stx, sty;

  assign x_go = (sdx_r < sdy_r);
  assign stx  = rx_r[RAY_W-1] ? '1 : COORD_W'(1);
  assign sty  = ry_r[RAY_W-1] ? '1 : COORD_W'(1);
  assign nx   = x_go ? mx_r + stx : mx_r;
  assign ny   = x_go ? my_r : my_r + sty;
  assign oob  = nx[COORD_W-1] || ny[COORD_W-1]
             || (nx[COORD_W-2:0] >= (COORD_W-1)'(MAP_SIZE))
             || (ny[COORD_W-2:0] >= (COORD_W-1)'(MAP_SIZE));
  assign ram_raddr = {nx[MAP_AW-1:0], ny[MAP_AW-1:0]};
  assign ram_we    = (cmd.op == OP_MAPWR);

  grc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_cell_x, in_cell_y}),
    .wdata (in_cell_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic cell_hit;
  assign cell_hit = !oob_r && (ram_rdata != '0);

  assign status.div_busy = div_busy;
  assign status.walk_hit = cell_hit;
  assign status.walk_end = oob_r || (n_r == STEP_CW'(MAX_STEPS));

  // perpendicular distance
  logic [SD_W-1:0] perp_full;
  assign perp_full = side_r ? sdy_r - SD_W'(dy_r) : sdx_r - SD_W'(dx_r);

  // wall hit fraction, only the low 28 bits matter
  logic [15:0]        w_pos;
  logic [RAY_W-1:0]   w_ray;
  logic [27:0]        w_ray28;
  logic [55:0]        w_prod;
  logic [27:0]        w_frac;
  logic [TEX_BITS-1:0] w_tx;
  logic               w_mirror;

  assign w_pos    = side_r ? pos_x_r : pos_y_r;
  assign w_ray    = side_r ? rx_r : ry_r;
  assign w_ray28  = 28'(signed'(w_ray));
  assign w_prod   = perp_r[27:0] * w_ray28;
  assign w_frac   = {w_pos[10:0], 17'd0} + w_prod[27:0];
  assign w_tx     = w_frac[27:28-TEX_BITS];
  assign w_mirror = (!side_r && !rx_r[RAY_W-1] && (rx_r != '0))
                 || (side_r && ry_r[RAY_W-1]);

  // span and texture start
  logic [14:0] half;
  logic [14:0] base;
  logic [36:0] tp_prod;
  logic [7:0]  ds, de;

  assign half    = lh_r[15:1];
  assign base    = (half > HALF_H15) ? half - HALF_H15 : '0;
  assign tp_prod = base * ts_r;
  assign ds      = (half >= HALF_H15) ? 8'd0 : 8'(HALF_H15 - half);
  assign de      = (half >= HALF_H15) ? 8'(SCREEN_H) : 8'(half + HALF_H15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= 16'd36864;
      pos_y_r   <= 16'd12288;
      dir_x_r   <= -16'sd4096;
      dir_y_r   <= 16'sd0;
      plane_x_r <= 16'sd0;
      plane_y_r <= 16'sd2703;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POS_X:   pos_x_r   <= cfg_data;
        REG_POS_Y:   pos_y_r   <= cfg_data;
        REG_DIR_X:   dir_x_r   <= cfg_data;
        REG_DIR_Y:   dir_y_r   <= cfg_data;
        REG_PLANE_X: plane_x_r <= cfg_data;
        REG_PLANE_Y: plane_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        col_r <= in_column;
      end
      OP_CAM_SAVE: begin
        cam_r <= CAM_W'(cam_prod[30:CAM_SH]) - CAM_W'(65536);
      end
      OP_RAYX: begin
        rx_r <= ray_sum;
      end
      OP_RAYY: begin
        ry_r <= ray_sum;
      end
      OP_DX_SAVE: begin
        dx_r <= (magx == '0) ? DELTA_INF : DELTA_W'(div_q);
      end
      OP_DY_SAVE: begin
        dy_r <= (magy == '0) ? DELTA_INF : DELTA_W'(div_q);
      end
      OP_SIDEX: begin
        sdx_r <= SD_W'(sd_prod >> 11);
      end
      OP_SIDEY: begin
        sdy_r  <= SD_W'(sd_prod >> 11);
        mx_r   <= COORD_W'(pos_x_r[15:11]);
        my_r   <= COORD_W'(pos_y_r[15:11]);
        n_r    <= '0;
        side_r <= 1'b0;
        hit_r  <= 1'b0;
      end
      OP_STEP: begin
        if (x_go) begin
          sdx_r  <= sdx_r + SD_W'(dx_r);
          side_r <= 1'b0;
        end else begin
          sdy_r  <= sdy_r + SD_W'(dy_r);
          side_r <= 1'b1;
        end
        mx_r  <= nx;
        my_r  <= ny;
        oob_r <= oob;
        n_r   <= n_r + 1'b1;
      end
      OP_CHECK: begin
        hit_r  <= cell_hit;
        cell_r <= ram_rdata;
      end
      OP_PERP: begin
        perp_r <= (perp_full[SD_W-1:PERP_W] != '0) ? '1 : perp_full[PERP_W-1:0];
      end
      OP_LH_SAVE: begin
        if (perp_r == '0 || div_q[DIV_W-1:16] != '0) begin
          lh_r <= LH_MAX;
        end else begin
          lh_r <= div_q[15:0];
        end
      end
      OP_TS_SAVE: begin
        if (lh_r == '0 || div_q[DIV_W-1:22] != '0) begin
          ts_r <= TS_MAX;
        end else begin
          ts_r <= div_q[21:0];
        end
      end
      OP_TEX: begin
        tx_r <= w_mirror ? ~w_tx : w_tx;
      end
      OP_TPOS: begin
        tp_r <= (tp_prod[36:22] != '0) ? TS_MAX : tp_prod[21:0];
      end
      OP_OUT: begin
        o_col_r  <= col_r;
        o_hit_r  <= hit_r;
        o_side_r <= hit_r && side_r;
        o_tidx_r <= hit_r ? cell_r - 1'b1 : '0;
        o_tcol_r <= hit_r ? 6'(tx_r) : '0;
        o_wd_r   <= !hit_r ? '0 : (perp_r[31:22] != '0) ? LH_MAX : perp_r[21:6];
        o_lh_r   <= hit_r ? lh_r : '0;
        o_ds_r   <= hit_r ? ds : '0;
        o_de_r   <= hit_r ? de : '0;
        o_ts_r   <= hit_r ? ts_r : '0;
        o_tp_r   <= hit_r ? tp_r : '0;
      end
      default: begin
      end
    endcase
  end

  assign out_column_out     = o_col_r;
  assign out_hit_found      = o_hit_r;
  assign out_hit_side       = o_side_r;
  assign out_texture_index  = o_tidx_r;
  assign out_texture_column = o_tcol_r;
  assign out_wall_distance  = o_wd_r;
  assign out_line_height    = o_lh_r;
  assign out_draw_start     = o_ds_r;
  assign out_draw_end       = o_de_r;
  assign out_texture_step   = o_ts_r;
  assign out_texture_start  = o_tp_r;

endmodule
